>>> rtl/core/ptw_pkg.sv
// Shared types and constants for the four-level page table walker.
// No dependencies; imported by the walker top level and its checker.
`timescale 1ns / 1ps

package ptw_pkg;

    // Store geometry.
    localparam int TABLE_COUNT       = 8;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int STORE_WORDS       = TABLE_COUNT * ENTRIES_PER_TABLE;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int TBL_W             = $clog2(TABLE_COUNT);
    localparam int ADDR_W            = TBL_W + IDX_W;

    // Entry layout.
    localparam int ENTRY_W   = 64;
    localparam int FRAME_W   = 40;
    localparam int PHYS_W    = 52;
    localparam int VA_W      = 48;
    localparam int ROOT_W    = 3;
    localparam int BIT_PRESENT = 0;
    localparam int BIT_LARGE   = 7;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ROOT_TABLE_ADDR = 3'd0;

    typedef enum logic [1:0] {
        OP_WRITE     = 2'd0,
        OP_TRANSLATE = 2'd1,
        OP_CLR_SMALL = 2'd2,
        OP_CLR_LARGE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOMAP = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t              opcode;
        logic [11:0]          entry_index;
        logic [ENTRY_W-1:0]   entry_value;
        logic [VA_W-1:0]      virt_addr;
    } in_word_t;

    typedef struct packed {
        status_t              status;
        logic [PHYS_W-1:0]    phys_addr;
        logic                 large_page;
    } out_word_t;

endpackage

>>> rtl/core/four_level_page_table_walker.sv
// Four-level page table walker: table store, walk sequencer and APB register.
// Depends on ptw_pkg.
`timescale 1ns / 1ps

// The walker holds TABLE_COUNT page tables of 512 64-bit entries in one
// single-port memory with a registered read, and serves one operation per
// word: write a raw entry, translate a 48-bit virtual address, clear a 4 KiB
// mapping or clear a 2 MiB mapping. After reset the block sweeps the memory
// to zero, one entry per cycle, over all TABLE_COUNT*512 entries (4096
// in the default build); s_ready stays low during that pass, while the APB
// register may be written as usual. Each walk level costs one memory read,
// and each read's data is registered and examined by the next walk state,
// so the memory port sets the pace. An entry write loads its result from
// the start state, a 2 MiB translate or either clear from the level 2
// state, and a 4 KiB translate from the level 1 state; a walk that fails
// at an upper level ends sooner. s_ready comes back as a result is loaded.
// The block takes one word at a time and is ready again even while its last
// result still waits in the output register, but every sequencer step after
// acceptance holds while a previous result has not been taken, so a stalled
// receiver halts the walk at its next step. The root table number is the
// only register, at byte address 0.

module four_level_page_table_walker
    import ptw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_data,

    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_L4,
        S_L3,
        S_L2,
        S_L1
    } state_t;

    // Table store.
    logic [ENTRY_W-1:0] mem [STORE_WORDS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;

    // Sequencer state.
    state_t             state_reg,     state_next;
    logic [ADDR_W-1:0]  clr_cnt_reg,   clr_cnt_next;
    logic [ADDR_W-1:0]  walk_addr_reg, walk_addr_next;
    in_word_t           item_reg;
    logic [ROOT_W-1:0]  root_table_reg;
    logic               m_valid_reg,   m_valid_next;
    out_word_t          m_data_reg,    m_data_next;

    logic               can_finish;
    logic               res_load;
    logic               cfg_write;
    logic [FRAME_W-1:0] frame;
    logic               frame_out;
    logic [PHYS_W-1:0]  phys_large;
    logic [PHYS_W-1:0]  phys_small;

    // Table number carried by a frame field that is already known in range.
    function automatic logic [TBL_W-1:0] tbl_of(input logic [FRAME_W-1:0] f);
        return f[TBL_W-1:0];
    endfunction

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ROOT_TABLE_ADDR);
    assign prdata    = (paddr == ROOT_TABLE_ADDR) ? PDATA_W'(root_table_reg) : '0;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A result may be loaded when the output register is empty or being drained.
    assign can_finish = !m_valid_reg || m_ready;

    // The entry just read, viewed as a table pointer or a page frame.
    assign frame      = rd_data_reg[51:12];
    assign frame_out  = frame >= FRAME_W'(TABLE_COUNT);
    assign phys_large = {rd_data_reg[51:21], item_reg.virt_addr[20:0]};
    assign phys_small = {rd_data_reg[51:12], item_reg.virt_addr[11:0]};

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        walk_addr_next = walk_addr_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = walk_addr_reg;
        mem_wdata      = '0;
        res_load       = 1'b0;
        m_data_next    = m_data_reg;

        if (res_load == 1'b0) begin
            m_data_next = m_data_reg;
        end

        unique case (state_reg)
            S_CLEAR: begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(STORE_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_START;
                end
            end

            S_START: begin
                if (can_finish) begin
                    if (item_reg.opcode == OP_WRITE) begin
                        res_load   = 1'b1;
                        state_next = S_IDLE;
                        if (32'(item_reg.entry_index) < STORE_WORDS) begin
                            mem_we      = 1'b1;
                            mem_addr    = ADDR_W'(item_reg.entry_index);
                            mem_wdata   = item_reg.entry_value;
                            m_data_next = '{status: ST_DONE, phys_addr: '0, large_page: 1'b0};
                        end else begin
                            m_data_next = '{status: ST_RANGE, phys_addr: '0, large_page: 1'b0};
                        end
                    end else if (FRAME_W'(root_table_reg) >= FRAME_W'(TABLE_COUNT)) begin
                        res_load    = 1'b1;
                        state_next  = S_IDLE;
                        m_data_next = '{status: ST_RANGE, phys_addr: '0, large_page: 1'b0};
                    end else begin
                        mem_re     = 1'b1;
                        mem_addr   = {tbl_of(FRAME_W'(root_table_reg)),
                                      item_reg.virt_addr[47:39]};
                        state_next = S_L4;
                    end
                end
            end

            S_L4, S_L3: begin
                if (can_finish) begin
                    if (!rd_data_reg[BIT_PRESENT]) begin
                        res_load    = 1'b1;
                        state_next  = S_IDLE;
                        m_data_next = '{status: ST_NOMAP, phys_addr: '0, large_page: 1'b0};
                    end else if (frame_out) begin
                        res_load    = 1'b1;
                        state_next  = S_IDLE;
                        m_data_next = '{status: ST_RANGE, phys_addr: '0, large_page: 1'b0};
                    end else begin
                        mem_re = 1'b1;
                        if (state_reg == S_L4) begin
                            mem_addr   = {tbl_of(frame), item_reg.virt_addr[38:30]};
                            state_next = S_L3;
                        end else begin
                            walk_addr_next = {tbl_of(frame), item_reg.virt_addr[29:21]};
                            mem_addr       = walk_addr_next;
                            state_next     = S_L2;
                        end
                    end
                end
            end

            S_L2: begin
                if (can_finish) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    if (item_reg.opcode == OP_CLR_LARGE) begin
                        // Any present level 2 entry is dropped, table pointer or not.
                        if (rd_data_reg[BIT_PRESENT]) begin
                            mem_we      = 1'b1;
                            mem_addr    = walk_addr_reg;
                            m_data_next = '{status: ST_DONE, phys_addr: '0, large_page: 1'b0};
                        end else begin
                            m_data_next = '{status: ST_NOMAP, phys_addr: '0, large_page: 1'b0};
                        end
                    end else if (!rd_data_reg[BIT_PRESENT]) begin
                        m_data_next = '{status: ST_NOMAP, phys_addr: '0, large_page: 1'b0};
                    end else if (rd_data_reg[BIT_LARGE]) begin
                        // A small-page clear under a large mapping changes nothing.
                        if (item_reg.opcode == OP_TRANSLATE) begin
                            m_data_next = '{status: ST_DONE, phys_addr: phys_large,
                                            large_page: 1'b1};
                        end else begin
                            m_data_next = '{status: ST_NOMAP, phys_addr: '0,
                                            large_page: 1'b0};
                        end
                    end else if (frame_out) begin
                        m_data_next = '{status: ST_RANGE, phys_addr: '0, large_page: 1'b0};
                    end else if (item_reg.opcode == OP_CLR_SMALL) begin
                        // The level 1 entry is zeroed whether or not it was present.
                        mem_we      = 1'b1;
                        mem_addr    = {tbl_of(frame), item_reg.virt_addr[20:12]};
                        m_data_next = '{status: ST_DONE, phys_addr: '0, large_page: 1'b0};
                    end else begin
                        res_load   = 1'b0;
                        mem_re     = 1'b1;
                        mem_addr   = {tbl_of(frame), item_reg.virt_addr[20:12]};
                        state_next = S_L1;
                    end
                end
            end

            S_L1: begin
                if (can_finish) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    if (rd_data_reg[BIT_PRESENT]) begin
                        m_data_next = '{status: ST_DONE, phys_addr: phys_small,
                                        large_page: 1'b0};
                    end else begin
                        m_data_next = '{status: ST_NOMAP, phys_addr: '0, large_page: 1'b0};
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Single-port table store with a registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            root_table_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_write) begin
                root_table_reg <= pwdata[ROOT_W-1:0];
            end
        end

        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        walk_addr_reg <= walk_addr_next;
        m_data_reg    <= m_data_next;
    end

endmodule

>>> rtl/core/ptw_checker.sv
// Port-level checker for the page table walker, bound to its top level.
// Depends on ptw_pkg and four_level_page_table_walker.
`timescale 1ns / 1ps

module ptw_checker
    import ptw_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // The store is still being cleared in the cycle after reset.
    a_no_accept_after_reset: assert property (
        @(posedge aclk) !aresetn |=> !s_ready
    ) else $error("walker ready right after reset");

    // A result word holds until it is taken.
    a_result_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data))
    ) else $error("result word dropped or changed while stalled");

    // Only a successful walk carries an address or the large-page flag.
    a_fail_is_clean: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_DONE) |->
            (m_data.phys_addr == '0 && !m_data.large_page)
    ) else $error("failed operation reports an address");

    a_status_code: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_DONE || m_data.status == ST_NOMAP ||
                     m_data.status == ST_RANGE)
    ) else $error("undefined status code");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (.*);
